### src/epv_pkg.sv
`default_nettype none

package epv_pkg;

    // Block sizing
    localparam int CHANNELS  = 3;
    localparam int AVG_DEPTH = 5;

    // Field widths
    localparam int CH_W  = 2;
    localparam int IVL_W = 16;
    localparam int CNT_W = 32;
    localparam int NUM_W = 18;
    localparam int SPD_W = 19;

    // Window sum holds AVG_DEPTH signed speed samples without overflow
    localparam int SUM_W     = SPD_W + $clog2(AVG_DEPTH);
    localparam int SLOT_W    = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int WIN_DEPTH = CHANNELS * AVG_DEPTH;
    localparam int WIN_IDX_W = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;
    localparam int DIV_CNT_W = $clog2(SUM_W + 1);

    // Stream payload widths, rounded up to whole bytes
    localparam int S_TDATA_W = ((CH_W + IVL_W + 1 + 1 + CNT_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((CH_W + CNT_W + SPD_W + 7) / 8) * 8;

    localparam logic [NUM_W-1:0] NUM_RESET = NUM_W'(224399);
    localparam logic [NUM_W-1:0] SPEED_MAX = NUM_W'(262143);

    typedef enum logic
    {
        OP_CAPTURE = 1'b0,
        OP_LOAD    = 1'b1
    } op_t;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_APPLY,
        S_SPEED,
        S_WINDOW,
        S_AVG,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

### src/encoder_position_velocity.sv
`default_nettype none

// Three-channel quadrature encoder position and speed tracker. Each input beat
// is either a capture (s_tuser = 0) or a position load (s_tuser = 1) for one
// channel, and produces exactly one output beat with that channel's position
// count and five-sample moving-average speed. Speed is speed_numerator divided
// by the channel's elapsed timer ticks, computed by a bit-serial restoring
// divider that resolves one quotient bit per cycle; the same divider then
// divides the window sum by the window depth. A capture runs both divisions, a
// load only the averaging one, and an item naming a channel outside the range
// neither. The result is offered as the block returns to idle and can accept
// the next beat. One item is in work at a time; the output register lets the
// next item be accepted while the previous result waits. speed_numerator is to
// be written with cfg_wr_en only while the block is idle; the block itself does
// not enforce this.
module encoder_position_velocity
    import epv_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 cfg_wr_en,
    input  wire logic [NUM_W-1:0]     cfg_wr_data,     // speed_numerator

    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // channel[1:0], capture_interval[17:2], level_a[18], level_b[19],
    // load_value[51:20], zero fill above
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic                 s_tuser,         // opcode

    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // out_channel[1:0], position[33:2], average_speed[52:34], zero fill above
    output logic [M_TDATA_W-1:0]      m_tdata
);

    localparam int IVL_LO  = CH_W;
    localparam int A_BIT   = IVL_LO + IVL_W;
    localparam int B_BIT   = A_BIT + 1;
    localparam int LOAD_LO = B_BIT + 1;

    state_t state_reg;
    state_t state_next;

    // Configuration and stored state
    logic [NUM_W-1:0]        num_reg;
    logic [CNT_W-1:0]        pos_reg     [CHANNELS];
    logic [CNT_W-1:0]        elapsed_reg [CHANNELS];
    logic signed [SPD_W-1:0] win_reg     [WIN_DEPTH];
    logic signed [SUM_W-1:0] sum_reg     [CHANNELS];
    logic [SLOT_W-1:0]       slot_reg    [CHANNELS];

    // Held item
    op_t              op_reg;
    logic [CH_W-1:0]  ch_reg;
    logic [IVL_W-1:0] ivl_reg;
    logic             up_reg;
    logic [CNT_W-1:0] load_reg;

    // Serial divider
    logic [SUM_W-1:0]     div_rem_reg;
    logic [SUM_W-1:0]     div_quo_reg;
    logic [CNT_W-1:0]     div_dvs_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic                 neg_reg;

    logic signed [SPD_W-1:0] avg_reg;
    logic                    m_tvalid_reg;
    logic [M_TDATA_W-1:0]    m_tdata_reg;

    logic                    ch_ok;
    logic                    out_load;
    logic                    div_last;
    logic [IVL_W-1:0]        ivl_eff;
    logic [CNT_W-1:0]        elapsed_add [CHANNELS];
    logic [SUM_W:0]          trial;
    logic                    fits;
    logic [CNT_W-1:0]        diff;
    logic [NUM_W-1:0]        quo_clip;
    logic signed [SPD_W-1:0] spd;
    logic [WIN_IDX_W-1:0]    win_idx;
    logic signed [SUM_W-1:0] sum_new;
    logic signed [SUM_W-1:0] sum_src;
    logic [CNT_W-1:0]        pos_out;

    assign ch_ok    = 32'(ch_reg) < CHANNELS;
    assign div_last = div_cnt_reg == DIV_CNT_W'(SUM_W - 1);
    assign ivl_eff  = (ivl_reg == '0) ? IVL_W'(1) : ivl_reg;

    // Add the interval to every channel's elapsed time, saturating
    always_comb
    begin
        for (int i = 0; i < CHANNELS; i++)
        begin
            logic [CNT_W:0] t;
            t = {1'b0, elapsed_reg[i]} + (CNT_W + 1)'(ivl_eff);
            elapsed_add[i] = t[CNT_W] ? '1 : t[CNT_W-1:0];
        end
    end

    // One restoring division step
    assign trial = {div_rem_reg, div_quo_reg[SUM_W-1]};
    assign fits  = CNT_W'(trial) >= div_dvs_reg;
    assign diff  = CNT_W'(trial) - div_dvs_reg;

    // Clip the speed quotient and apply the count direction
    assign quo_clip = (div_quo_reg > SUM_W'(SPEED_MAX)) ? SPEED_MAX
                                                        : div_quo_reg[NUM_W-1:0];
    assign spd      = up_reg ? SPD_W'(quo_clip) : -SPD_W'(quo_clip);

    // Window slot of the active channel
    always_comb
    begin
        win_idx = '0;
        sum_new = '0;
        if (ch_ok)
        begin
            win_idx = WIN_IDX_W'(32'(ch_reg) * AVG_DEPTH + 32'(slot_reg[ch_reg]));
            sum_new = sum_reg[ch_reg] - SUM_W'(win_reg[win_idx]) + SUM_W'(spd);
        end
    end

    assign sum_src = (state_reg == S_WINDOW) ? sum_new
                                             : (ch_ok ? sum_reg[ch_reg] : '0);
    assign pos_out = ch_ok ? pos_reg[ch_reg] : '0;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                    state_next = S_APPLY;
            end
            S_APPLY:
            begin
                priority if (!ch_ok)
                    state_next = S_DONE;
                else if (op_reg == OP_LOAD)
                    state_next = S_AVG;
                else
                    state_next = S_SPEED;
            end
            S_SPEED:
            begin
                if (div_last)
                    state_next = S_WINDOW;
            end
            S_WINDOW:
                state_next = S_AVG;
            S_AVG:
            begin
                if (div_last)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Handshake outputs
    always_comb
    begin
        s_tready = state_reg == S_IDLE;
        out_load = (state_reg == S_DONE) && (!m_tvalid_reg || m_tready);
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Advance the sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Hold the speed numerator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            num_reg <= NUM_RESET;
        else if (cfg_wr_en)
            num_reg <= cfg_wr_data;
    end

    // Take the item apart on acceptance
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            op_reg   <= op_t'(s_tuser);
            ch_reg   <= s_tdata[CH_W-1:0];
            ivl_reg  <= s_tdata[A_BIT-1:IVL_LO];
            up_reg   <= s_tdata[A_BIT] == s_tdata[B_BIT];
            load_reg <= s_tdata[LOAD_LO+CNT_W-1:LOAD_LO];
        end
    end

    // Channel state: counts, elapsed times, speed windows
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                pos_reg[i]     <= '0;
                elapsed_reg[i] <= '0;
                sum_reg[i]     <= '0;
                slot_reg[i]    <= '0;
            end
            for (int j = 0; j < WIN_DEPTH; j++)
                win_reg[j] <= '0;
        end
        else if (state_reg == S_APPLY && ch_ok)
        begin
            if (op_reg == OP_LOAD)
                pos_reg[ch_reg] <= load_reg;
            else
            begin
                // Age every channel, clear the capturing one
                for (int i = 0; i < CHANNELS; i++)
                    elapsed_reg[i] <= (CH_W'(i) == ch_reg) ? '0 : elapsed_add[i];
                pos_reg[ch_reg] <= up_reg ? pos_reg[ch_reg] + CNT_W'(1)
                                          : pos_reg[ch_reg] - CNT_W'(1);
            end
        end
        else if (state_reg == S_WINDOW)
        begin
            win_reg[win_idx] <= spd;
            sum_reg[ch_reg]  <= sum_new;
            if (slot_reg[ch_reg] == SLOT_W'(AVG_DEPTH - 1))
                slot_reg[ch_reg] <= '0;
            else
                slot_reg[ch_reg] <= slot_reg[ch_reg] + SLOT_W'(1);
        end
    end

    // Serial divider: load operands, then shift one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_APPLY:
            begin
                div_rem_reg <= '0;
                div_cnt_reg <= '0;
                if (op_reg == OP_LOAD)
                begin
                    neg_reg     <= sum_src[SUM_W-1];
                    div_quo_reg <= sum_src[SUM_W-1] ? -sum_src : sum_src;
                    div_dvs_reg <= CNT_W'(AVG_DEPTH);
                end
                else
                begin
                    div_quo_reg <= SUM_W'(num_reg);
                    div_dvs_reg <= ch_ok ? elapsed_add[ch_reg] : CNT_W'(1);
                end
            end
            S_WINDOW:
            begin
                div_rem_reg <= '0;
                div_cnt_reg <= '0;
                neg_reg     <= sum_src[SUM_W-1];
                div_quo_reg <= sum_src[SUM_W-1] ? -sum_src : sum_src;
                div_dvs_reg <= CNT_W'(AVG_DEPTH);
            end
            S_SPEED, S_AVG:
            begin
                div_rem_reg <= fits ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
                div_quo_reg <= {div_quo_reg[SUM_W-2:0], fits};
                div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    // Signed window average, or zero for a channel out of range
    always_ff @(posedge clk)
    begin
        if (state_reg == S_APPLY && !ch_ok)
            avg_reg <= '0;
        else if (state_reg == S_AVG && div_last)
        begin
            if (neg_reg)
                avg_reg <= -SPD_W'({div_quo_reg[SUM_W-2:0], fits});
            else
                avg_reg <= SPD_W'({div_quo_reg[SUM_W-2:0], fits});
        end
    end

    // Output register: drop the beat on acceptance, load the next result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (out_load)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            m_tdata_reg <= M_TDATA_W'({avg_reg, pos_out, ch_reg});
    end

    // No second beat is taken while an item is in work
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input beat accepted while an item is in work");

    // Divider remainder always stays below the divisor
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SPEED || state_reg == S_AVG)
            |-> (CNT_W'(div_rem_reg) < div_dvs_reg))
        else $error("divider remainder reached the divisor");

    // Capturing channel's elapsed time is cleared before its window update
    a_elapsed_clr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WINDOW && ch_ok) |-> (elapsed_reg[ch_reg] == '0))
        else $error("elapsed time not cleared after capture");

    // A new result appears only out of the result state
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == S_DONE))
        else $error("output beat raised outside the result state");

endmodule

`default_nettype wire
